### sv/srle_pkg.sv
// ----------------------------------------------------------------------------
// srle_pkg
// Shared types, register map and colour expansion for the sprite RLE decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srle_pkg;

    localparam int CFG_ADDR_BITS = 4;

    localparam logic [7:0] CTRL_SKIP = 8'hff;
    localparam logic [7:0] CTRL_NOP  = 8'h00;

    localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd1;
    localparam logic [12:0] ROW_PITCH_RESET   = 13'd4096;
    localparam logic [23:0] BASE_OFFSET_RESET = 24'd0;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROW_PITCH   = 2'd1;
    localparam logic [1:0] REG_BASE_OFFSET = 2'd2;

    // quotient bits of a skip: column + count stays below 2^13
    localparam int          QUOT_BITS = 13;
    localparam logic [3:0]  TOP_SHIFT = 4'(QUOT_BITS - 1);

    typedef enum logic [1:0] {
        PH_CONTROL,
        PH_SKIP,
        PH_LOW,
        PH_HIGH
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PIX
    } t_state;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       first_byte;
    } t_in_word;

    typedef struct packed {
        logic [23:0] write_addr;
        logic [31:0] pixel_color;
    } t_out_word;

    typedef struct packed {
        logic [11:0] image_width;
        logic [12:0] row_pitch;
        logic [23:0] base_offset;
    } t_cfg;

    // RGB555 to ARGB8888, top bits of each channel replicated, alpha opaque
    function automatic logic [31:0] widen_color(input logic [15:0] c);
        widen_color = {8'hff,
                       c[14:10], c[14:12],
                       c[9:5],   c[9:7],
                       c[4:0],   c[4:2]};
    endfunction

endpackage

`default_nettype wire

### sv/sprite_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// sprite_rle_pixel_decoder_unit
// Run-length sprite decoder: RGB555 literals to ARGB8888 atlas writes.
// ----------------------------------------------------------------------------
// Takes the compressed sprite one byte per input word and emits one output
// word (atlas address and ARGB8888 colour) per literal pixel. Control, skip
// marker and pixel low bytes do not stall the input, which is ready again at
// once. A skip count is loaded, then divided in 13 restoring-division steps
// on the shared compare/subtract unit, which folds column + count against
// the image width and adds the shifted atlas pitch to the row offset for
// each set quotient bit. A pixel high byte is loaded, then the pixel state
// forms the address and advances the column through the same unit; that
// state holds while the output word is stalled. The output word sits in a
// register, so control and low bytes keep flowing while a result waits.
// Registers: image width at 0x0, atlas pitch at 0x4, base offset at 0x8;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rle_pixel_decoder_unit
    import srle_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input words
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_in_word                 i_in_word,
    // output words
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output t_out_word                     o_out_word,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SW = (ADDR_BITS > 24) ? ADDR_BITS : 24;

    t_cfg w_cfg;

    srle_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // control state
    t_state                 r_state,     n_state;
    t_phase                 r_phase,     n_phase;
    logic [7:0]             r_lit,       n_lit;
    logic [11:0]            r_column,    n_column;
    logic [ADDR_BITS-1:0]   r_row,       n_row;
    logic [3:0]             r_shift,     n_shift;
    logic                   r_out_valid, n_out_valid;
    // payload
    logic [7:0]             r_low,       n_low;
    logic [7:0]             r_high,      n_high;
    logic [QUOT_BITS-1:0]   r_rem,       n_rem;
    t_out_word              r_out_word,  n_out_word;

    // shared step unit
    logic [11:0]            w_width;
    logic [QUOT_BITS-1:0]   w_unit_rem_in;
    logic [3:0]             w_unit_shift;
    logic [QUOT_BITS-1:0]   w_unit_rem;
    logic [ADDR_BITS-1:0]   w_unit_row;

    // a zero width counts as one
    assign w_width = (w_cfg.image_width == 12'd0) ? 12'd1 : w_cfg.image_width;

    // a literal runs one step at shift zero on column + 1
    assign w_unit_rem_in = (r_state == ST_PIX) ? (QUOT_BITS'(r_column) + QUOT_BITS'(1))
                                               : r_rem;
    assign w_unit_shift  = (r_state == ST_PIX) ? 4'd0 : r_shift;

    srle_div_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .i_rem     (w_unit_rem_in),
        .i_divisor (w_width),
        .i_shift   (w_unit_shift),
        .i_row     (r_row),
        .i_pitch   (w_cfg.row_pitch),
        .o_rem     (w_unit_rem),
        .o_row     (w_unit_row)
    );

    // atlas address: wrap at ADDR_BITS, then keep 24 bits
    logic [SW-1:0] w_addr_sum;
    logic [SW-1:0] w_addr_wrap;

    assign w_addr_sum  = SW'(w_cfg.base_offset) + SW'(r_row) + SW'(r_column);
    assign w_addr_wrap = SW'(w_addr_sum[ADDR_BITS-1:0]);

    // effective state of an accepted byte after the first-byte restart
    t_phase               w_phase_eff;
    logic [11:0]          w_col_eff;
    logic [ADDR_BITS-1:0] w_row_eff;
    logic [7:0]           w_lit_eff;
    logic [7:0]           w_low_eff;
    logic [7:0]           w_byte;

    assign w_byte      = i_in_word.stream_byte;
    assign w_phase_eff = i_in_word.first_byte ? PH_CONTROL : r_phase;
    assign w_col_eff   = i_in_word.first_byte ? 12'd0 : r_column;
    assign w_row_eff   = i_in_word.first_byte ? '0 : r_row;
    assign w_lit_eff   = i_in_word.first_byte ? 8'd0 : r_lit;
    assign w_low_eff   = i_in_word.first_byte ? 8'd0 : r_low;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_lit       = r_lit;
        n_column    = r_column;
        n_row       = r_row;
        n_shift     = r_shift;
        n_low       = r_low;
        n_high      = r_high;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        // drop the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_column = w_col_eff;
                    n_row    = w_row_eff;
                    n_lit    = w_lit_eff;
                    n_low    = w_low_eff;
                    case (w_phase_eff)
                        PH_CONTROL: begin
                            if (w_byte == CTRL_SKIP) begin
                                n_phase = PH_SKIP;
                            end else if (w_byte != CTRL_NOP) begin
                                n_lit   = w_byte;
                                n_phase = PH_LOW;
                            end
                        end
                        PH_SKIP: begin
                            // start the division of column + count by width
                            n_rem   = QUOT_BITS'(w_col_eff) + QUOT_BITS'(w_byte);
                            n_shift = TOP_SHIFT;
                            n_state = ST_DIV;
                        end
                        PH_LOW: begin
                            n_low   = w_byte;
                            n_phase = PH_HIGH;
                        end
                        PH_HIGH: begin
                            n_high  = w_byte;
                            n_state = ST_PIX;
                        end
                        default: n_phase = PH_CONTROL;
                    endcase
                end
            end
            ST_DIV: begin
                n_rem = w_unit_rem;
                n_row = w_unit_row;
                if (r_shift == 4'd0) begin
                    n_column = w_unit_rem[11:0];
                    n_phase  = PH_CONTROL;
                    n_state  = ST_IDLE;
                end else begin
                    n_shift = r_shift - 4'd1;
                end
            end
            ST_PIX: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_word.write_addr   = w_addr_wrap[23:0];
                    n_out_word.pixel_color  = widen_color({r_high, r_low});
                    n_column                = w_unit_rem[11:0];
                    n_row                   = w_unit_row;
                    n_lit                   = r_lit - 8'd1;
                    n_phase                 = (r_lit == 8'd1) ? PH_CONTROL : PH_LOW;
                    n_state                 = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_CONTROL;
            r_lit       <= 8'd0;
            r_column    <= 12'd0;
            r_row       <= '0;
            r_shift     <= 4'd0;
            r_out_valid <= 1'b0;
            r_low       <= 8'd0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_lit       <= n_lit;
            r_column    <= n_column;
            r_row       <= n_row;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
            r_low       <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_high     <= n_high;
        r_rem      <= n_rem;
        r_out_word <= n_out_word;
    end

endmodule

`default_nettype wire

### sv/srle_cfg_regs.sv
// ----------------------------------------------------------------------------
// srle_cfg_regs
// APB-style register file: image width, atlas pitch and base offset.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_cfg_regs
    import srle_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH: n_cfg.image_width = pwdata[11:0];
                REG_ROW_PITCH:   n_cfg.row_pitch   = pwdata[12:0];
                REG_BASE_OFFSET: n_cfg.base_offset = pwdata[23:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width <= IMAGE_WIDTH_RESET;
            r_cfg.row_pitch   <= ROW_PITCH_RESET;
            r_cfg.base_offset <= BASE_OFFSET_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH: prdata = {20'd0, r_cfg.image_width};
            REG_ROW_PITCH:   prdata = {19'd0, r_cfg.row_pitch};
            REG_BASE_OFFSET: prdata = {8'd0, r_cfg.base_offset};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/srle_div_step.sv
// ----------------------------------------------------------------------------
// srle_div_step
// One restoring-division step: compare and subtract the shifted width, and
// add the matching shifted pitch to the row offset when the step is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_div_step
    import srle_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic [QUOT_BITS-1:0] i_rem,
    input  wire logic [11:0]          i_divisor,
    input  wire logic [3:0]           i_shift,
    input  wire logic [ADDR_BITS-1:0] i_row,
    input  wire logic [12:0]          i_pitch,
    output logic [QUOT_BITS-1:0]      o_rem,
    output logic [ADDR_BITS-1:0]      o_row
);

    localparam int DW = 12 + QUOT_BITS;
    localparam int PW = ADDR_BITS + QUOT_BITS;

    logic [DW-1:0] w_div_sh;
    logic [DW-1:0] w_rem_ext;
    logic [DW-1:0] w_diff;
    logic [PW-1:0] w_pitch_sh;
    logic          w_take;

    assign w_div_sh   = DW'(i_divisor) << i_shift;
    assign w_rem_ext  = DW'(i_rem);
    assign w_take     = w_rem_ext >= w_div_sh;
    assign w_diff     = w_rem_ext - w_div_sh;
    assign w_pitch_sh = PW'(i_pitch) << i_shift;

    assign o_rem = w_take ? w_diff[QUOT_BITS-1:0] : i_rem;
    assign o_row = w_take ? (i_row + w_pitch_sh[ADDR_BITS-1:0]) : i_row;

endmodule

`default_nettype wire

### sv/srle_checker.sv
// ----------------------------------------------------------------------------
// srle_checker
// Port-level checks of the sprite RLE decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_checker
    import srle_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // a fresh result traces back to an input word accepted just before the pixel-forming state
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without an accepted pixel byte");

    // the input is stalled while a pixel is being formed
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("input open while pixel was formed");

    // every decoded pixel is opaque
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.pixel_color[31:24] == 8'hff))
        else $error("pixel alpha not opaque");

endmodule

bind sprite_rle_pixel_decoder_unit srle_checker u_srle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sprite RLE pixel decoder.
// ----------------------------------------------------------------------------
// Streams compressed sprite bytes into the decoder and predicts every
// decoded pixel word on the side. The prediction covers skip folding into
// rows, literal runs, first-byte restarts and address wrap. A monitor checks
// each output word against the oldest pending prediction. The directed tests
// cover the byte extremes, zero widths and a width lowered mid-sprite. The
// random phases send mostly well-formed sprites under several register
// settings, with noise and cut-off runs mixed in. The sender works in bursts
// with gaps, and the receiver stalls in a changing pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import srle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    // a skip count keeps the block busy, with no output word, while it divides
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_BYTES   = 250;
    localparam int PHASE_COUNT   = 8;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    t_in_word                 i_in_word   = '0;
    logic                     i_out_stall = 1'b0;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr       = '0;
    logic [31:0]              pwdata      = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    t_out_word                o_out_word;
    logic [31:0]              prdata;
    logic                     pready;

    sprite_rle_pixel_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder shadow: its own copy of the registers and the parse state
    // ------------------------------------------------------------------------
    t_cfg        dec_cfg   = '{IMAGE_WIDTH_RESET, ROW_PITCH_RESET, BASE_OFFSET_RESET};
    t_phase      dec_phase = PH_CONTROL;
    logic [7:0]  dec_left  = '0;
    logic [7:0]  dec_low   = '0;
    logic [11:0] dec_col   = '0;
    logic [23:0] dec_row   = '0;

    // predicted pixel words, oldest first
    t_out_word   pixel_q[$];

    int          err_count   = 0;
    int          sent_count  = 0;
    int          cycle_count = 0;

    // widen a 5-bit channel to 8 bits by repeating its top bits underneath
    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, 3'b000} | 8'(v >> 2);
    endfunction

    function automatic logic [31:0] argb_from_rgb555(input logic [15:0] c);
        // bit 15 carries nothing
        return {8'hff, expand5(c[14:10]), expand5(c[9:5]), expand5(c[4:0])};
    endfunction

    // Advance the shadow by one accepted input word and queue any pixel.
    function automatic void decode_byte(input t_in_word w);
        int unsigned wdt;
        int unsigned sum;
        int unsigned rows;
        int unsigned nxt;
        t_out_word   px;

        wdt = (dec_cfg.image_width == 12'd0) ? 1 : dec_cfg.image_width;

        // a first byte drops whatever was in progress and restarts at the origin
        if (w.first_byte) begin
            dec_phase = PH_CONTROL;
            dec_left  = '0;
            dec_low   = '0;
            dec_col   = '0;
            dec_row   = '0;
        end

        case (dec_phase)
            PH_CONTROL: begin
                if (w.stream_byte == CTRL_SKIP) begin
                    dec_phase = PH_SKIP;
                end else if (w.stream_byte != CTRL_NOP) begin
                    dec_left  = w.stream_byte;
                    dec_phase = PH_LOW;
                end
            end
            PH_SKIP: begin
                // fold the skip into whole rows; also pulls an oversized column back
                sum       = dec_col + w.stream_byte;
                rows      = sum / wdt;
                dec_col   = 12'(sum % wdt);
                dec_row   = dec_row + 24'(rows * dec_cfg.row_pitch);
                dec_phase = PH_CONTROL;
            end
            PH_LOW: begin
                dec_low   = w.stream_byte;
                dec_phase = PH_HIGH;
            end
            default: begin
                px.write_addr  = dec_cfg.base_offset + dec_row + {12'd0, dec_col};
                px.pixel_color = argb_from_rgb555({w.stream_byte, dec_low});
                pixel_q = {pixel_q, px};
                // only one width is taken off, even if the column was far past it
                nxt = dec_col + 1;
                if (nxt >= wdt) begin
                    nxt     = nxt - wdt;
                    dec_row = dec_row + 24'(dec_cfg.row_pitch);
                end
                dec_col   = 12'(nxt);
                dec_left  = dec_left - 8'd1;
                dec_phase = (dec_left == 8'd0) ? PH_CONTROL : PH_LOW;
            end
        endcase
    endfunction

    function automatic void check_pixel(input t_out_word got);
        t_out_word want;

        if (pixel_q.size() == 0) begin
            $display("%0t: unexpected output word, expected none, actual %h", $time, got);
            err_count++;
        end else begin
            want = pixel_q.pop_front();
            if (got.write_addr !== want.write_addr) begin
                $display("%0t: write_addr mismatch, expected %h, actual %h",
                         $time, want.write_addr, got.write_addr);
                err_count++;
            end
            if (got.pixel_color !== want.pixel_color) begin
                $display("%0t: pixel_color mismatch, expected %h, actual %h",
                         $time, want.pixel_color, got.pixel_color);
                err_count++;
            end
        end
    endfunction

    // Both handshakes are sampled at the edge, before any update of this step.
    // Check first so an output word never meets a prediction made at the
    // same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_pixel(o_out_word);
            end
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_word);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern that switches between random modes
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left  <= mode_left - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 9) < 6);
            end
            default: begin
                // long runs of stall and release
                if (hold_left == 0) begin
                    i_out_stall <= !i_out_stall;
                    hold_left   <= $urandom_range(1, 20);
                end else begin
                    hold_left   <= hold_left - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sprite_rle_pixel_decoder_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    bit valid_held = 0;
    int burst_left = 0;
    bit next_first = 0;

    // Present one input word and hold it until it is taken. Within a burst the
    // valid stays high so the next call can swap the payload at the same edge.
    task automatic send_byte(input logic [7:0] b, input logic f);
        i_in_valid <= 1'b1;
        i_in_word  <= '{stream_byte: b, first_byte: f};
        valid_held = 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            valid_held = 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Send a byte that opens a command; it carries a pending restart flag.
    task automatic send_cmd(input logic [7:0] b);
        send_byte(b, next_first);
        next_first = 0;
    endtask

    // Drop valid and wait out every predicted word.
    task automatic drain_results();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 0;
        end
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then give a trailing skip time to finish before touching registers.
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== want) begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, want, prdata);
            err_count++;
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // register taken at this edge; mirror it
        case (idx)
            REG_IMAGE_WIDTH: dec_cfg.image_width = val[11:0];
            REG_ROW_PITCH:   dec_cfg.row_pitch   = val[12:0];
            default:         dec_cfg.base_offset = val[23:0];
        endcase
        case (idx)
            REG_IMAGE_WIDTH: want = {20'd0, dec_cfg.image_width};
            REG_ROW_PITCH:   want = {19'd0, dec_cfg.row_pitch};
            default:         want = {8'd0, dec_cfg.base_offset};
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        apb_read_check(idx, want);
    endtask

    task automatic cfg_all(input logic [31:0] wdt, input logic [31:0] pitch,
                           input logic [31:0] base);
        cfg_write(REG_IMAGE_WIDTH, wdt);
        cfg_write(REG_ROW_PITCH, pitch);
        cfg_write(REG_BASE_OFFSET, base);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_values();
        apb_read_check(REG_IMAGE_WIDTH, {20'd0, IMAGE_WIDTH_RESET});
        @(posedge i_clk);
        apb_read_check(REG_ROW_PITCH, {19'd0, ROW_PITCH_RESET});
        @(posedge i_clk);
        apb_read_check(REG_BASE_OFFSET, {8'd0, BASE_OFFSET_RESET});
        @(posedge i_clk);
    endtask

    // Byte extremes near the top of the atlas, so the address wraps.
    task automatic test_extreme_bytes();
        cfg_all(32'd4095, 32'd4096, 32'h00ff_fffe);
        send_byte(CTRL_NOP, 1'b1);
        send_byte(CTRL_SKIP, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(CTRL_SKIP, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        // cut a run short with a new sprite
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
    endtask

    // Width 0 acts as 1; pitch 0 lands every row on the same address.
    task automatic test_zero_widths();
        settle_block();
        cfg_all(32'd0, 32'd0, $urandom_range(0, 32'h00ff_ffff));
        send_byte(8'h02, 1'b1);
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Lower the width while the column sits far beyond it.
    task automatic test_width_lowered();
        settle_block();
        cfg_all(32'd200, 32'd300, 32'd5);
        send_byte(CTRL_SKIP, 1'b1);
        send_byte(8'd150, 1'b0);
        settle_block();
        cfg_write(REG_IMAGE_WIDTH, 32'd10);
        @(posedge i_clk);
        send_byte(8'h01, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        // the next skip brings the column back in range
        send_byte(CTRL_SKIP, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // One random command: mostly skips and literal runs, some noise and cuts.
    task automatic emit_command();
        int r;
        int n;
        int k;

        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end else if (r < 9) begin
            next_first = 1;
        end else if (r < 32) begin
            send_cmd(CTRL_SKIP);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 36) begin
            send_cmd(CTRL_NOP);
        end else begin
            r = $urandom_range(0, 99);
            n = (r < 88) ? $urandom_range(1, 8) : (r < 99) ? $urandom_range(9, 64) : 254;
            send_cmd(n[7:0]);
            // now and then break the run off early
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : n;
            repeat (k) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic test_random_sprites();
        int phase;
        int start;
        bit paused;

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle_block();
            case (phase)
                0: cfg_all(32'd4095, 32'd4096, 32'h00ff_ffff);
                1: cfg_all(32'd1, 32'd1, 32'd0);
                2: cfg_all(32'd0, 32'd0, $urandom_range(0, 32'h00ff_ffff));
                default: begin
                    cfg_all(($urandom_range(0, 1) == 0) ? $urandom_range(1, 16)
                                                        : $urandom_range(1, 4095),
                            ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                        : $urandom_range(0, 4096),
                            $urandom_range(0, 32'h00ff_ffff));
                end
            endcase
            // sometimes carry on with the old sprite under the new settings
            next_first = ($urandom_range(0, 3) != 0);
            start  = sent_count;
            paused = 0;
            while (sent_count - start < PHASE_BYTES) begin
                emit_command();
                // hold the stream once per phase until every pixel is out
                if (!paused && sent_count - start >= PHASE_BYTES / 2) begin
                    drain_results();
                    paused = 1;
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_extreme_bytes();
        test_zero_widths();
        test_width_lowered();
        test_random_sprites();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("sprite_rle_pixel_decoder_unit test passed");
        end else begin
            $display("sprite_rle_pixel_decoder_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
